// ===== hw/rtl/gcr_pkg.sv =====
// Shared types, constants and helpers for the GPIO controller register block.
`timescale 1ns / 1ps

package gcr_pkg;

   localparam int NUM_PINS = 58;

   localparam logic [7:0] ADDR_SET  = 8'h1c;
   localparam logic [7:0] ADDR_CLR  = 8'h28;
   localparam logic [7:0] ADDR_LEV  = 8'h34;
   localparam logic [7:0] ADDR_EDS  = 8'h40;
   localparam logic [7:0] ADDR_REN  = 8'h4c;
   localparam logic [7:0] ADDR_FEN  = 8'h58;
   localparam logic [7:0] ADDR_PULL = 8'he4;

   localparam int FSEL_WORDS    = 7;
   localparam int PULL_WORDS    = 4;
   localparam int FSEL_PER_WORD = 10;
   localparam int PULL_PER_WORD = 16;

   localparam logic [2:0] FUNC_OUTPUT = 3'd1;
   localparam logic [1:0] PULL_UP     = 2'd1;
   localparam logic [1:0] PULL_DOWN   = 2'd2;

   typedef enum logic [1:0] {
      REQ_READ   = 2'd0,
      REQ_WRITE  = 2'd1,
      REQ_SAMPLE = 2'd2,
      REQ_NOP    = 2'd3
   } req_kind_type;

   typedef logic [NUM_PINS-1:0] pins_type;

   typedef struct packed {
      logic       is_fsel;
      logic [2:0] fsel_word;
      logic       is_pull;
      logic [1:0] pull_word;
      logic       is_set;
      logic       is_clr;
      logic       is_lev;
      logic       is_eds;
      logic       is_ren;
      logic       is_fen;
      logic       bank;
   } gcr_dec_type;

   typedef struct packed {
      pins_type out_latch;
      pins_type out_enable;
      pins_type pull_up;
      pins_type pull_down;
      logic     irq_low;
      logic     irq_high;
   } gcr_view_type;

   // 32-bit bank word placed on the pin vector
   function automatic pins_type bank_bits(input logic [31:0] data, input logic bank);
      logic [63:0] w;
      w = bank ? {data, 32'h0} : {32'h0, data};
      return w[NUM_PINS-1:0];
   endfunction

   function automatic logic [31:0] bank_read(input pins_type vec, input logic bank);
      logic [63:0] w;
      w = 64'(vec);
      return bank ? w[63:32] : w[31:0];
   endfunction

   function automatic pins_type bank_replace(input pins_type vec, input logic [31:0] data,
                                             input logic bank);
      pins_type keep;
      keep = ~bank_bits(32'hffff_ffff, bank);
      return (vec & keep) | bank_bits(data, bank);
   endfunction

endpackage

// ===== hw/rtl/gcr_decode.sv =====
// Register address decode for the GPIO controller register block.
`timescale 1ns / 1ps

module gcr_decode import gcr_pkg::*; (
   input  logic [7:0]  reg_offset,
   output gcr_dec_type dec
);

   logic [5:0] word;
   logic [5:0] pull_idx;

   localparam logic [5:0] W_SET  = ADDR_SET[7:2];
   localparam logic [5:0] W_CLR  = ADDR_CLR[7:2];
   localparam logic [5:0] W_LEV  = ADDR_LEV[7:2];
   localparam logic [5:0] W_EDS  = ADDR_EDS[7:2];
   localparam logic [5:0] W_REN  = ADDR_REN[7:2];
   localparam logic [5:0] W_FEN  = ADDR_FEN[7:2];
   localparam logic [5:0] W_PULL = ADDR_PULL[7:2];

   always_comb begin
      word     = reg_offset[7:2];
      pull_idx = 6'(word - W_PULL);

      dec.is_fsel   = (word < 6'(FSEL_WORDS));
      dec.fsel_word = word[2:0];
      dec.is_pull   = (word >= W_PULL) && (pull_idx < 6'(PULL_WORDS));
      dec.pull_word = pull_idx[1:0];
      dec.is_set    = (word == W_SET) || (word == 6'(W_SET + 6'd1));
      dec.is_clr    = (word == W_CLR) || (word == 6'(W_CLR + 6'd1));
      dec.is_lev    = (word == W_LEV) || (word == 6'(W_LEV + 6'd1));
      dec.is_eds    = (word == W_EDS) || (word == 6'(W_EDS + 6'd1));
      dec.is_ren    = (word == W_REN) || (word == 6'(W_REN + 6'd1));
      dec.is_fen    = (word == W_FEN) || (word == 6'(W_FEN + 6'd1));
      dec.bank      = (word == 6'(W_SET + 6'd1)) || (word == 6'(W_CLR + 6'd1)) ||
                      (word == 6'(W_LEV + 6'd1)) || (word == 6'(W_EDS + 6'd1)) ||
                      (word == 6'(W_REN + 6'd1)) || (word == 6'(W_FEN + 6'd1));
   end

endmodule

// ===== hw/rtl/gcr_regfile.sv =====
// Pin state registers, read mux and update logic of the GPIO controller.
`timescale 1ns / 1ps

module gcr_regfile import gcr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         proc_en,
   input  req_kind_type kind,
   input  gcr_dec_type  dec,
   input  logic [31:0]  write_data,
   input  pins_type     pin_levels,
   output logic [31:0]  read_data,
   output gcr_view_type view_in
);

   logic [2:0] fsel_ff [NUM_PINS];
   logic [2:0] fsel_in [NUM_PINS];
   logic [1:0] pull_ff [NUM_PINS];
   logic [1:0] pull_in [NUM_PINS];
   pins_type   outv_ff, outv_in;
   pins_type   lev_ff, lev_in;
   pins_type   levb_ff, levb_in;
   pins_type   eds_ff, eds_in;
   pins_type   ren_ff, ren_in;
   pins_type   fen_ff, fen_in;

   always_comb begin
      fsel_in = fsel_ff;
      pull_in = pull_ff;
      outv_in = outv_ff;
      lev_in  = lev_ff;
      levb_in = levb_ff;
      eds_in  = eds_ff;
      ren_in  = ren_ff;
      fen_in  = fen_ff;
      if (proc_en) begin
         unique case (kind)
            REQ_WRITE: begin
               for (int p = 0; p < NUM_PINS; p++) begin
                  if (dec.is_fsel && dec.fsel_word == 3'(p / FSEL_PER_WORD))
                     fsel_in[p] = write_data[3*(p % FSEL_PER_WORD) +: 3];
                  if (dec.is_pull && dec.pull_word == 2'(p / PULL_PER_WORD))
                     pull_in[p] = write_data[2*(p % PULL_PER_WORD) +: 2];
               end
               if (dec.is_set) outv_in = outv_ff | bank_bits(write_data, dec.bank);
               if (dec.is_clr) outv_in = outv_ff & ~bank_bits(write_data, dec.bank);
               if (dec.is_eds) eds_in = eds_ff & ~bank_bits(write_data, dec.bank);
               if (dec.is_ren) ren_in = bank_replace(ren_ff, write_data, dec.bank);
               if (dec.is_fen) fen_in = bank_replace(fen_ff, write_data, dec.bank);
            end
            REQ_SAMPLE: begin
               levb_in = lev_ff;
               lev_in  = pin_levels;
               eds_in  = eds_ff | (~lev_ff & pin_levels & ren_ff)
                                | (lev_ff & ~pin_levels & fen_ff);
            end
            default: begin
            end
         endcase
      end
   end

   // read data comes from the state before this request
   always_comb begin
      read_data = 32'h0;
      if (kind == REQ_READ) begin
         for (int p = 0; p < NUM_PINS; p++) begin
            if (dec.is_fsel && dec.fsel_word == 3'(p / FSEL_PER_WORD))
               read_data[3*(p % FSEL_PER_WORD) +: 3] = fsel_ff[p];
            if (dec.is_pull && dec.pull_word == 2'(p / PULL_PER_WORD))
               read_data[2*(p % PULL_PER_WORD) +: 2] = pull_ff[p];
         end
         if (dec.is_lev) read_data = bank_read(lev_ff, dec.bank);
         if (dec.is_eds) read_data = bank_read(eds_ff, dec.bank);
         if (dec.is_ren) read_data = bank_read(ren_ff, dec.bank);
         if (dec.is_fen) read_data = bank_read(fen_ff, dec.bank);
      end
   end

   always_comb begin
      logic [63:0] eds_w;
      eds_w = 64'(eds_in);
      for (int p = 0; p < NUM_PINS; p++) begin
         view_in.out_enable[p] = (fsel_in[p] == FUNC_OUTPUT);
         view_in.pull_up[p]    = (pull_in[p] == PULL_UP);
         view_in.pull_down[p]  = (pull_in[p] == PULL_DOWN);
      end
      view_in.out_latch = outv_in;
      view_in.irq_low   = |eds_w[31:0];
      view_in.irq_high  = |eds_w[63:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PINS; p++) begin
            fsel_ff[p] <= 3'd0;
            pull_ff[p] <= 2'd0;
         end
         outv_ff <= '0;
         lev_ff  <= '0;
         levb_ff <= '0;
         eds_ff  <= '0;
         ren_ff  <= '0;
         fen_ff  <= '0;
      end else begin
         fsel_ff <= fsel_in;
         pull_ff <= pull_in;
         outv_ff <= outv_in;
         lev_ff  <= lev_in;
         levb_ff <= levb_in;
         eds_ff  <= eds_in;
         ren_ff  <= ren_in;
         fen_ff  <= fen_in;
      end
   end

endmodule

// ===== hw/rtl/gpio_controller_registers_unit.sv =====
// Top level of the GPIO controller register block: request and response stages.
`timescale 1ns / 1ps

// A request (register read, register write or pin level sample) is taken into
// an input register, then decoded and applied to the pin state once the output
// register is empty or being taken, and its response, showing the state after
// the request, sits in the output register until taken. One request per cycle
// is sustained while responses are taken; a held response stalls the input
// register. Unmapped offsets read zero and ignore writes; request type 3
// changes nothing.
module gpio_controller_registers_unit import gcr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_reg_offset,
   input  logic [31:0] req_write_data,
   input  pins_type    req_pin_levels,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output pins_type    rsp_out_latch,
   output pins_type    rsp_out_enable,
   output pins_type    rsp_pull_up_mask,
   output pins_type    rsp_pull_down_mask,
   output logic        rsp_irq_low_bank,
   output logic        rsp_irq_high_bank
);

   logic         in_valid_ff;
   req_kind_type kind_ff;
   logic [7:0]   offset_ff;
   logic [31:0]  wdata_ff;
   pins_type     pins_ff;

   logic         rsp_valid_ff;
   logic [31:0]  rdata_ff;
   gcr_view_type view_ff;

   logic         advance;
   gcr_dec_type  dec;
   logic [31:0]  rdata_in;
   gcr_view_type view_in;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   gcr_decode u_decode (
      .reg_offset (offset_ff),
      .dec        (dec)
   );

   gcr_regfile u_regfile (
      .clock      (clock),
      .reset      (reset),
      .proc_en    (advance),
      .kind       (kind_ff),
      .dec        (dec),
      .write_data (wdata_ff),
      .pin_levels (pins_ff),
      .read_data  (rdata_in),
      .view_in    (view_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff   <= req_kind_type'(req_type);
         offset_ff <= req_reg_offset;
         wdata_ff  <= req_write_data;
         pins_ff   <= req_pin_levels;
      end
      if (advance) begin
         rdata_ff <= rdata_in;
         view_ff  <= view_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rdata_ff;
   assign rsp_out_latch      = view_ff.out_latch;
   assign rsp_out_enable     = view_ff.out_enable;
   assign rsp_pull_up_mask   = view_ff.pull_up;
   assign rsp_pull_down_mask = view_ff.pull_down;
   assign rsp_irq_low_bank   = view_ff.irq_low;
   assign rsp_irq_high_bank  = view_ff.irq_high;

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input stage dropped a pending request");

   a_rsp_after_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request produced no response");

   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !advance |=> !rsp_valid_ff)
      else $error("taken response was repeated");

   a_stall_no_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !advance)
      else $error("request processed while response stalled");

endmodule
